// ===== rtl/hsfp_pkg.sv =====
// ----------------------------------------------------------------------------
// HID serial frame parser package
// Shared widths, frame constants, parser states and the report record.
// ----------------------------------------------------------------------------
package hsfp_pkg;

  localparam int BYTE_W        = 8;
  localparam int CNT_W         = 4;
  localparam int PAYLOAD_BYTES = 8;
  localparam int IDX_W         = $clog2(PAYLOAD_BYTES);

  localparam logic [BYTE_W-1:0] HDR_FIRST    = 8'h57;
  localparam logic [BYTE_W-1:0] HDR_SECOND   = 8'hAB;
  localparam logic [BYTE_W-1:0] HDR_TYPE     = 8'h00;
  localparam logic [BYTE_W-1:0] CMD_MOUSE    = 8'h01;
  localparam logic [BYTE_W-1:0] CMD_KEYBOARD = 8'h02;
  localparam logic [BYTE_W-1:0] LEN_MOUSE    = 8'h05;
  localparam logic [BYTE_W-1:0] LEN_KEYBOARD = 8'h08;

  localparam logic [BYTE_W-1:0] HDR_SUM = BYTE_W'(HDR_FIRST + HDR_SECOND + HDR_TYPE);

  localparam logic KIND_KEYBOARD = 1'b0;
  localparam logic KIND_MOUSE    = 1'b1;

  typedef enum logic [6:0] {
    ST_HDR1 = 7'b0000001,
    ST_HDR2 = 7'b0000010,
    ST_TYPE = 7'b0000100,
    ST_CMD  = 7'b0001000,
    ST_LEN  = 7'b0010000,
    ST_DATA = 7'b0100000,
    ST_SUM  = 7'b1000000
  } hunt_state_t;

  typedef struct packed {
    logic                     report_kind;
    logic        [BYTE_W-1:0] control_bits;
    logic        [BYTE_W-1:0] key_code_0;
    logic        [BYTE_W-1:0] key_code_1;
    logic        [BYTE_W-1:0] key_code_2;
    logic        [BYTE_W-1:0] key_code_3;
    logic        [BYTE_W-1:0] key_code_4;
    logic        [BYTE_W-1:0] key_code_5;
    logic signed [BYTE_W-1:0] move_x;
    logic signed [BYTE_W-1:0] move_y;
    logic signed [BYTE_W-1:0] wheel_step;
  } report_t;

endpackage

// ===== rtl/hsfp_stream_if.sv =====
// ----------------------------------------------------------------------------
// HID serial frame parser channels
// Valid/ready channels for received bytes and for decoded reports.
// ----------------------------------------------------------------------------
interface hsfp_byte_if;
  import hsfp_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hsfp_report_if;
  import hsfp_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     report_kind;
  logic        [BYTE_W-1:0] control_bits;
  logic        [BYTE_W-1:0] key_code_0;
  logic        [BYTE_W-1:0] key_code_1;
  logic        [BYTE_W-1:0] key_code_2;
  logic        [BYTE_W-1:0] key_code_3;
  logic        [BYTE_W-1:0] key_code_4;
  logic        [BYTE_W-1:0] key_code_5;
  logic signed [BYTE_W-1:0] move_x;
  logic signed [BYTE_W-1:0] move_y;
  logic signed [BYTE_W-1:0] wheel_step;

  modport source (
    output valid, output report_kind, output control_bits,
    output key_code_0, output key_code_1, output key_code_2,
    output key_code_3, output key_code_4, output key_code_5,
    output move_x, output move_y, output wheel_step,
    input ready
  );
  modport sink (
    input valid, input report_kind, input control_bits,
    input key_code_0, input key_code_1, input key_code_2,
    input key_code_3, input key_code_4, input key_code_5,
    input move_x, input move_y, input wheel_step,
    output ready
  );
endinterface

// ===== rtl/hid_serial_frame_parser.sv =====
// ----------------------------------------------------------------------------
// HID serial frame parser
// Hunts for mouse and keyboard frames in a byte stream and emits one report
// for every frame whose checksum matches.
// ----------------------------------------------------------------------------
//  channel | direction | item
//  rx      | in        | one received byte (rx_byte)
//  rpt     | out       | one keyboard or mouse report
//
// Each byte passes an input register and then updates the parser state and
// the report register in one step, so a new byte is taken every cycle unless
// a report stalls; each report is registered behind the input register.
// Reset clears the parser to wait for the first header byte and empties
// both registers. A stalled report holds the pipe only when the input
// register must advance into the occupied report register.
module hid_serial_frame_parser (
  input  logic                 clk,
  input  logic                 rst,
  hsfp_byte_if.sink            rx,
  hsfp_report_if.source        rpt
);
  import hsfp_pkg::*;

  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              take;

  hunt_state_t       hunt_state;
  hunt_state_t       hunt_state_next;
  logic              command_kind;
  logic              command_kind_next;
  logic [CNT_W-1:0]  payload_length;
  logic [CNT_W-1:0]  payload_length_next;
  logic [CNT_W-1:0]  payload_count;
  logic [CNT_W-1:0]  payload_count_next;
  logic [CNT_W-1:0]  count_inc;
  logic [BYTE_W-1:0] running_sum;
  logic [BYTE_W-1:0] running_sum_next;
  logic [BYTE_W-1:0] payload_store [PAYLOAD_BYTES];
  logic              store_we;
  logic              emit;

  logic              out_valid;
  report_t           out_report;
  report_t           report_next;

  assign take     = in_valid && (!out_valid || rpt.ready);
  assign rx.ready = !in_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
    if (rx.valid && rx.ready) begin
      in_byte <= rx.rx_byte;
    end
  end

  assign count_inc = payload_count + CNT_W'(1);

  always_comb begin
    hunt_state_next     = hunt_state;
    command_kind_next   = command_kind;
    payload_length_next = payload_length;
    payload_count_next  = payload_count;
    running_sum_next    = running_sum;
    store_we            = 1'b0;
    emit                = 1'b0;
    case (hunt_state)
      ST_HDR1: begin
        if (in_byte == HDR_FIRST) begin
          hunt_state_next = ST_HDR2;
        end
      end
      ST_HDR2: begin
        hunt_state_next = (in_byte == HDR_SECOND) ? ST_TYPE : ST_HDR1;
      end
      ST_TYPE: begin
        hunt_state_next = (in_byte == HDR_TYPE) ? ST_CMD : ST_HDR1;
      end
      ST_CMD: begin
        if (in_byte == CMD_MOUSE || in_byte == CMD_KEYBOARD) begin
          command_kind_next = (in_byte == CMD_KEYBOARD);
          hunt_state_next   = ST_LEN;
        end else begin
          hunt_state_next = ST_HDR1;
        end
      end
      ST_LEN: begin
        if ((!command_kind && in_byte == LEN_MOUSE) ||
            (command_kind && in_byte == LEN_KEYBOARD)) begin
          payload_length_next = in_byte[CNT_W-1:0];
          payload_count_next  = '0;
          running_sum_next    = HDR_SUM + (command_kind ? CMD_KEYBOARD : CMD_MOUSE) + in_byte;
          hunt_state_next     = ST_DATA;
        end else begin
          hunt_state_next = ST_HDR1;
        end
      end
      ST_DATA: begin
        store_we           = (32'(payload_count) < PAYLOAD_BYTES);
        running_sum_next   = running_sum + in_byte;
        payload_count_next = count_inc;
        if (count_inc >= payload_length) begin
          hunt_state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        emit            = (in_byte == running_sum);
        hunt_state_next = ST_HDR1;
      end
      default: begin
        hunt_state_next = ST_HDR1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hunt_state <= ST_HDR1;
    end else if (take) begin
      hunt_state <= hunt_state_next;
    end
    if (take) begin
      command_kind   <= command_kind_next;
      payload_length <= payload_length_next;
      payload_count  <= payload_count_next;
      running_sum    <= running_sum_next;
    end
    if (take && store_we) begin
      payload_store[IDX_W'(payload_count)] <= in_byte;
    end
  end

  always_comb begin
    report_next              = '0;
    report_next.control_bits = payload_store[0];
    if (command_kind) begin
      report_next.report_kind = KIND_KEYBOARD;
      report_next.key_code_0  = payload_store[2];
      report_next.key_code_1  = payload_store[3];
      report_next.key_code_2  = payload_store[4];
      report_next.key_code_3  = payload_store[5];
      report_next.key_code_4  = payload_store[6];
      report_next.key_code_5  = payload_store[7];
    end else begin
      report_next.report_kind = KIND_MOUSE;
      report_next.move_x      = payload_store[1];
      report_next.move_y      = payload_store[2];
      report_next.wheel_step  = payload_store[3];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= emit;
    end else if (rpt.ready) begin
      out_valid <= 1'b0;
    end
    if (take && emit) begin
      out_report <= report_next;
    end
  end

  assign rpt.valid        = out_valid;
  assign rpt.report_kind  = out_report.report_kind;
  assign rpt.control_bits = out_report.control_bits;
  assign rpt.key_code_0   = out_report.key_code_0;
  assign rpt.key_code_1   = out_report.key_code_1;
  assign rpt.key_code_2   = out_report.key_code_2;
  assign rpt.key_code_3   = out_report.key_code_3;
  assign rpt.key_code_4   = out_report.key_code_4;
  assign rpt.key_code_5   = out_report.key_code_5;
  assign rpt.move_x       = out_report.move_x;
  assign rpt.move_y       = out_report.move_y;
  assign rpt.wheel_step   = out_report.wheel_step;

endmodule
